// ===== hdl/ecb_pkg.sv =====
// Package with shared types, codes and defaults of the event counter bank.
`default_nettype none

package ecb_pkg;

  localparam int ENTRY_COUNT_DEF = 64;
  localparam int HANDLE_BASE_DEF = 256;

  localparam logic [63:0] COUNT_MAX = 64'hffff_ffff_ffff_fffe;
  localparam logic [15:0] MIN_BYTES = 16'd8;

  typedef enum logic [1:0] {
    MODE_CREATE = 2'd0,
    MODE_READ   = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BADHANDLE  = 3'd2,
    ST_BADLEN     = 3'd3,
    ST_WOULDBLOCK = 3'd4,
    ST_RETRY      = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request word and start the counter read
    logic commit;  // apply the request and load the result register
  } ecb_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/ecb_if.sv =====
// Valid/ready channel interfaces for request and result words.
`default_nettype none

interface ecb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] handle;
  logic [63:0] value;
  logic        semaphore_mode;
  logic        nonblocking;
  logic [15:0] request_bytes;

  modport source (output valid, mode, handle, value, semaphore_mode, nonblocking,
                  request_bytes, input ready);
  modport sink   (input valid, mode, handle, value, semaphore_mode, nonblocking,
                  request_bytes, output ready);
endinterface

interface ecb_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] new_handle;
  logic [63:0] read_value;
  logic        readable;
  logic        writeable;

  modport source (output valid, status, new_handle, read_value, readable, writeable,
                  input ready);
  modport sink   (input valid, status, new_handle, read_value, readable, writeable,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/ecb_ctrl.sv =====
// Controller state machine that sequences one request at a time.
`default_nettype none

module ecb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ecb_pkg::ecb_cmd_t    cmd
);
  import ecb_pkg::*;

  fsm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register can take a new word when empty or being emptied.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) state_nxt = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (out_free) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      FSM_EXEC: begin
        cmd.commit = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ecb_dp.sv =====
// Datapath with the counter memory, fill count, request decode and result register.
`default_nettype none

module ecb_dp #(
  parameter int ENTRY_COUNT = ecb_pkg::ENTRY_COUNT_DEF,
  parameter int HANDLE_BASE = ecb_pkg::HANDLE_BASE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ecb_pkg::ecb_cmd_t cmd,
  input  wire logic [1:0]        in_mode,
  input  wire logic [15:0]       in_handle,
  input  wire logic [63:0]       in_value,
  input  wire logic              in_semaphore_mode,
  input  wire logic              in_nonblocking,
  input  wire logic [15:0]       in_request_bytes,
  output logic [2:0]             out_status,
  output logic [15:0]            out_new_handle,
  output logic [63:0]            out_read_value,
  output logic                   out_readable,
  output logic                   out_writeable
);
  import ecb_pkg::*;

  localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW = $clog2(ENTRY_COUNT + 1);
  localparam logic [15:0] BASE16  = 16'(HANDLE_BASE);
  localparam logic [15:0] DEPTH16 = 16'(ENTRY_COUNT);
  localparam logic [CW-1:0] DEPTH_CW = CW'(ENTRY_COUNT);

  // Each memory word holds {nonblocking, semaphore, count}.
  logic [65:0] mem [ENTRY_COUNT];
  logic [65:0] rdata_r;

  // Entries are taken lowest first and never freed, so the in-use set is
  // exactly the indexes below the fill count.
  logic [CW-1:0] fill_r, fill_nxt;

  mode_t       mode_r;
  logic [15:0] off_r;
  logic [63:0] value_r;
  logic        sem_r;
  logic        nb_r;
  logic [15:0] bytes_r;

  logic [15:0] in_off;
  logic [IW-1:0] rd_addr;

  logic [63:0] cur;
  logic        cur_sem, cur_nb;
  logic [64:0] sum;
  logic        hit;
  logic        we;
  logic [IW-1:0] wr_addr;
  logic [65:0] wdata;
  status_t     status_nxt;
  logic [15:0] new_handle_nxt;
  logic [63:0] read_value_nxt;
  logic        readable_nxt, writeable_nxt;

  assign in_off  = in_handle - BASE16;
  assign rd_addr = (in_off < DEPTH16) ? in_off[IW-1:0] : '0;

  assign cur     = rdata_r[63:0];
  assign cur_sem = rdata_r[64];
  assign cur_nb  = rdata_r[65];
  assign sum     = {1'b0, cur} + {1'b0, value_r};
  assign hit     = (off_r < DEPTH16) && (off_r < 16'(fill_r));

  always_comb begin
    fill_nxt       = fill_r;
    we             = 1'b0;
    wr_addr        = off_r[IW-1:0];
    wdata          = rdata_r;
    status_nxt     = ST_OK;
    new_handle_nxt = '0;
    read_value_nxt = '0;
    readable_nxt   = 1'b0;
    writeable_nxt  = 1'b0;
    unique case (mode_r)
      MODE_CREATE: begin
        if (fill_r == DEPTH_CW) begin
          status_nxt = ST_FULL;
        end else begin
          we             = 1'b1;
          wr_addr        = fill_r[IW-1:0];
          wdata          = {nb_r, sem_r, 32'd0, value_r[31:0]};
          new_handle_nxt = BASE16 + 16'(fill_r);
          fill_nxt       = fill_r + 1'b1;
        end
      end
      MODE_QUERY: begin
        if (!hit) begin
          status_nxt = ST_BADHANDLE;
        end else begin
          readable_nxt  = (cur != 64'd0);
          writeable_nxt = (cur < COUNT_MAX);
        end
      end
      MODE_READ: begin
        if (!hit) begin
          status_nxt = ST_BADHANDLE;
        end else if (bytes_r < MIN_BYTES) begin
          status_nxt = ST_BADLEN;
        end else if (cur == 64'd0) begin
          status_nxt = cur_nb ? ST_WOULDBLOCK : ST_RETRY;
        end else if (cur_sem) begin
          we             = 1'b1;
          wdata          = {cur_nb, cur_sem, cur - 64'd1};
          read_value_nxt = 64'd1;
        end else begin
          we             = 1'b1;
          wdata          = {cur_nb, cur_sem, 64'd0};
          read_value_nxt = cur;
        end
      end
      MODE_WRITE: begin
        if (!hit) begin
          status_nxt = ST_BADHANDLE;
        end else if (bytes_r < MIN_BYTES) begin
          status_nxt = ST_BADLEN;
        end else if (sum > {1'b0, COUNT_MAX}) begin
          status_nxt = cur_nb ? ST_WOULDBLOCK : ST_RETRY;
        end else begin
          we    = 1'b1;
          wdata = {cur_nb, cur_sem, sum[63:0]};
        end
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.commit) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd.commit && we) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mode_t'(in_mode);
      off_r   <= in_off;
      value_r <= in_value;
      sem_r   <= in_semaphore_mode;
      nb_r    <= in_nonblocking;
      bytes_r <= in_request_bytes;
    end
    if (cmd.commit) begin
      out_status     <= status_nxt;
      out_new_handle <= new_handle_nxt;
      out_read_value <= read_value_nxt;
      out_readable   <= readable_nxt;
      out_writeable  <= writeable_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/event_counter_bank_top.sv =====
// Top level of the event counter bank: controller, datapath and channel hookup.
//
// The block serves eventfd-style requests on a valid/ready request channel
// (in_ch) and returns exactly one result word per request on a valid/ready
// result channel (out_ch). A request word is taken when valid and ready are
// both high; the result word is delivered when out_ch valid and ready meet.
// Each request takes two steps: the accept cycle reads the counter memory
// through its registered read port, and the execute state then performs the
// single read-modify-write of that entry and loads the result register.
// The block takes no new request until the current one has been applied,
// a limit set by that memory access.
// A waiting result does not block the next accept; only when the result
// register is still full and not being emptied in the execute state does the
// block hold the request until the receiver takes the pending word.
// Synchronous active-low reset empties the result channel, returns the
// controller to idle and clears the fill count, which marks every entry as
// free at once; no clearing pass over the memory is needed because entries
// are handed out lowest first and never freed.
`default_nettype none

module event_counter_bank_top #(
  parameter int ENTRY_COUNT = ecb_pkg::ENTRY_COUNT_DEF,
  parameter int HANDLE_BASE = ecb_pkg::HANDLE_BASE_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ecb_in_if.sink    in_ch,
  ecb_out_if.source out_ch
);
  import ecb_pkg::*;

  // Commands travel from the controller to the datapath as one struct.
  ecb_cmd_t cmd;

  // The controller owns the handshakes and the result-valid flag.
  ecb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // The datapath holds the counters, flags, fill count and result payload.
  ecb_dp #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .HANDLE_BASE (HANDLE_BASE)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_mode           (in_ch.mode),
    .in_handle         (in_ch.handle),
    .in_value          (in_ch.value),
    .in_semaphore_mode (in_ch.semaphore_mode),
    .in_nonblocking    (in_ch.nonblocking),
    .in_request_bytes  (in_ch.request_bytes),
    .out_status        (out_ch.status),
    .out_new_handle    (out_ch.new_handle),
    .out_read_value    (out_ch.read_value),
    .out_readable      (out_ch.readable),
    .out_writeable     (out_ch.writeable)
  );

endmodule

`default_nettype wire

// ===== bench/event_counter_bank_top_tb.sv =====
// Self-checking testbench of the event counter bank: directed table, then random requests.
`timescale 1ns / 100ps

module event_counter_bank_top_tb;
  import ecb_pkg::*;

  localparam int ENTRIES = ENTRY_COUNT_DEF;
  localparam logic [15:0] BASE = 16'(HANDLE_BASE_DEF);
  localparam int NUM_DIRECTED = 26;
  localparam int NUM_CHUNKS = 17;
  localparam int CHUNK_ITEMS = 50;

  // One request word as the sender drives it.
  typedef struct packed {
    mode_t       mode;
    logic [15:0] handle;
    logic [63:0] value;
    logic        semaphore_mode;
    logic        nonblocking;
    logic [15:0] request_bytes;
  } request_t;

  // One result word as the receiver sees it.
  typedef struct packed {
    status_t     status;
    logic [15:0] new_handle;
    logic [63:0] read_value;
    logic        readable;
    logic        writeable;
  } response_t;

  // A directed step: the request and, where it is obvious, the result typed in by hand.
  typedef struct packed {
    request_t  rq;
    logic      fixed;
    response_t rs;
  } table_row_t;

  localparam response_t NO_FIXED = '0;

  logic clk = 1'b0;
  logic rst_n;

  ecb_in_if  in_bus();
  ecb_out_if out_bus();

  event_counter_bank_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // 10 ns clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the counter bank. It is advanced at the clock edge where a
  // request word is accepted, so it always reflects the order the block sees.
  logic        slot_used [ENTRIES];
  logic [63:0] slot_count [ENTRIES];
  logic        slot_sem [ENTRIES];
  logic        slot_nb [ENTRIES];
  int          slots_taken;

  // Results the block still owes, oldest first.
  response_t pending_responses[$];
  int        mismatch_count = 0;

  // Knobs that shape back-pressure on both channels; zero means no idling.
  int idle_pct;
  int stall_pct;

  // The typed-in result for the word currently on the request channel, if any.
  logic      held_fixed;
  response_t held_fixed_rs;

  table_row_t directed_rows [NUM_DIRECTED];

  // Applies one request to the shadow bank and returns the result word it earns.
  function automatic response_t bank_respond(input request_t rq);
    response_t rs;
    int        slot;
    int        idx;
    int        i;
    logic [15:0] offset;
    logic [63:0] cur;
    rs = NO_FIXED;
    rs.status = ST_OK;
    if (rq.mode == MODE_CREATE) begin
      slot = -1;
      for (i = 0; i < ENTRIES; i++) begin
        if (!slot_used[i] && slot < 0) slot = i;
      end
      if (slot < 0) begin
        rs.status = ST_FULL;
      end else begin
        slot_used[slot] = 1'b1;
        slot_count[slot] = {32'h0, rq.value[31:0]};
        slot_sem[slot] = rq.semaphore_mode;
        slot_nb[slot] = rq.nonblocking;
        slots_taken++;
        rs.new_handle = BASE + 16'(slot);
      end
    end else begin
      // Handles wrap modulo 2^16 before the range check.
      offset = rq.handle - BASE;
      idx = int'(offset);
      if (idx >= ENTRIES || !slot_used[idx]) begin
        rs.status = ST_BADHANDLE;
      end else if (rq.mode == MODE_QUERY) begin
        rs.readable = (slot_count[idx] != 64'd0);
        rs.writeable = (slot_count[idx] < COUNT_MAX);
      end else if (rq.request_bytes < MIN_BYTES) begin
        rs.status = ST_BADLEN;
      end else if (rq.mode == MODE_READ) begin
        if (slot_count[idx] == 64'd0) begin
          rs.status = slot_nb[idx] ? ST_WOULDBLOCK : ST_RETRY;
        end else if (slot_sem[idx]) begin
          rs.read_value = 64'd1;
          slot_count[idx] = slot_count[idx] - 64'd1;
        end else begin
          rs.read_value = slot_count[idx];
          slot_count[idx] = 64'd0;
        end
      end else begin
        cur = slot_count[idx];
        if (cur > COUNT_MAX || COUNT_MAX - cur < rq.value) begin
          rs.status = slot_nb[idx] ? ST_WOULDBLOCK : ST_RETRY;
        end else begin
          slot_count[idx] = cur + rq.value;
        end
      end
    end
    return rs;
  endfunction

  // Builds a random request. Most handles point at entries already handed out
  // so that reads and writes get past the lookup; the rest probe unused
  // entries, the space just past the bank, and arbitrary handles.
  function automatic request_t random_request();
    request_t    rq;
    int          pick;
    int          idx;
    logic [15:0] offset;
    logic [63:0] cur;
    pick = $urandom_range(0, 99);
    if (pick < 12) rq.mode = MODE_CREATE;
    else if (pick < 42) rq.mode = MODE_READ;
    else if (pick < 77) rq.mode = MODE_WRITE;
    else rq.mode = MODE_QUERY;

    pick = $urandom_range(0, 99);
    if (slots_taken > 0 && pick < 80)
      rq.handle = BASE + 16'($urandom_range(0, slots_taken - 1));
    else if (pick < 92)
      rq.handle = BASE + 16'($urandom_range(0, ENTRIES + 7));
    else
      rq.handle = 16'($urandom);

    offset = rq.handle - BASE;
    idx = int'(offset);
    cur = (idx < ENTRIES) ? slot_count[idx] : 64'd0;

    // Values near the headroom of the target counter hit the overflow edge.
    pick = $urandom_range(0, 99);
    if (pick < 25) rq.value = 64'($urandom_range(0, 20));
    else if (pick < 45) rq.value = {$urandom, $urandom};
    else if (pick < 65) rq.value = COUNT_MAX - cur + 64'($urandom_range(0, 3)) - 64'd1;
    else if (pick < 75) rq.value = 64'd0;
    else if (pick < 80) rq.value = '1;
    else rq.value = 64'($urandom);

    rq.semaphore_mode = 1'($urandom_range(0, 1));
    rq.nonblocking = 1'($urandom_range(0, 1));

    pick = $urandom_range(0, 99);
    if (pick < 8) rq.request_bytes = 16'($urandom_range(0, 7));
    else if (pick < 12) rq.request_bytes = 16'hffff;
    else if (pick < 20) rq.request_bytes = 16'($urandom);
    else rq.request_bytes = 16'($urandom_range(8, 64));
    return rq;
  endfunction

  // Presents one request word at the falling edge, after an optional idle
  // burst, and holds it until the block accepts it at a rising edge.
  task automatic put_request(input request_t rq, input logic fixed, input response_t fx);
    int gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 14);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.mode           <= rq.mode;
    in_bus.handle         <= rq.handle;
    in_bus.value          <= rq.value;
    in_bus.semaphore_mode <= rq.semaphore_mode;
    in_bus.nonblocking    <= rq.nonblocking;
    in_bus.request_bytes  <= rq.request_bytes;
    held_fixed            <= fixed;
    held_fixed_rs         <= fx;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  // Stops sending until every owed result has come back.
  task automatic hold_for_drain();
    in_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_responses.size() != 0);
  endtask

  // Rising-edge monitor. Accepted request words are pushed through the shadow
  // bank; accepted result words are compared with the oldest owed result.
  always @(posedge clk) begin : monitor
    request_t  seen;
    response_t want;
    response_t predicted;
    response_t got;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        seen.mode           = mode_t'(in_bus.mode);
        seen.handle         = in_bus.handle;
        seen.value          = in_bus.value;
        seen.semaphore_mode = in_bus.semaphore_mode;
        seen.nonblocking    = in_bus.nonblocking;
        seen.request_bytes  = in_bus.request_bytes;
        predicted = bank_respond(seen);
        pending_responses.push_back(held_fixed ? held_fixed_rs : predicted);
      end
      if (out_bus.valid && out_bus.ready) begin
        got.status     = status_t'(out_bus.status);
        got.new_handle = out_bus.new_handle;
        got.read_value = out_bus.read_value;
        got.readable   = out_bus.readable;
        got.writeable  = out_bus.writeable;
        if (pending_responses.size() == 0) begin
          $display("%0t: result word expected none actual status %0d", $time, got.status);
          mismatch_count++;
        end else begin
          want = pending_responses.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatch_count++;
          end
          if (got.new_handle !== want.new_handle) begin
            $display("%0t: new_handle expected %h actual %h", $time,
                     want.new_handle, got.new_handle);
            mismatch_count++;
          end
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time,
                     want.read_value, got.read_value);
            mismatch_count++;
          end
          if (got.readable !== want.readable) begin
            $display("%0t: readable expected %b actual %b", $time,
                     want.readable, got.readable);
            mismatch_count++;
          end
          if (got.writeable !== want.writeable) begin
            $display("%0t: writeable expected %b actual %b", $time,
                     want.writeable, got.writeable);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Result side: ready drops for random stall bursts.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, the directed table, then random chunks of requests.
  initial begin : stimulus
    int k;
    int chunk;
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_count[i] = 64'd0;
      slot_sem[i] = 1'b0;
      slot_nb[i] = 1'b0;
    end
    slots_taken = 0;
    idle_pct = 0;
    stall_pct = 0;

    // Directed steps walk one entry through draining, the overflow edge and
    // the zero-count wait, then a semaphore entry and a nonblocking entry.
    // Handle lookups before any create and handles that wrap around the
    // base or sit just past the bank must all be rejected.
    directed_rows = '{
      '{'{MODE_QUERY, 16'd256, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_BADHANDLE, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_READ, 16'd256, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_BADHANDLE, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_WRITE, 16'd256, 64'd1, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_BADHANDLE, 16'd0, 64'd0, 1'b0, 1'b0}},
      // Only the low half of the value seeds the counter.
      '{'{MODE_CREATE, 16'hffff, 64'hffff_ffff_0000_0005, 1'b0, 1'b0, 16'd0}, 1'b1,
        '{ST_OK, 16'd256, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_QUERY, 16'd256, 64'd0, 1'b0, 1'b0, 16'd0}, 1'b1,
        '{ST_OK, 16'd0, 64'd0, 1'b1, 1'b1}},
      '{'{MODE_READ, 16'd256, 64'd0, 1'b0, 1'b0, 16'd7}, 1'b1,
        '{ST_BADLEN, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_WRITE, 16'd256, 64'd3, 1'b0, 1'b0, 16'd0}, 1'b1,
        '{ST_BADLEN, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_QUERY, 16'd256, '1, 1'b1, 1'b1, 16'hffff}, 1'b0, NO_FIXED},
      '{'{MODE_READ, 16'd256, 64'd0, 1'b0, 1'b0, 16'hffff}, 1'b1,
        '{ST_OK, 16'd0, 64'd5, 1'b0, 1'b0}},
      '{'{MODE_READ, 16'd256, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_RETRY, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_QUERY, 16'd256, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_OK, 16'd0, 64'd0, 1'b0, 1'b1}},
      '{'{MODE_WRITE, 16'd256, COUNT_MAX, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_OK, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_QUERY, 16'd256, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_OK, 16'd0, 64'd0, 1'b1, 1'b0}},
      '{'{MODE_WRITE, 16'd256, 64'd1, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_RETRY, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_WRITE, 16'd256, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_OK, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_READ, 16'd256, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_OK, 16'd0, COUNT_MAX, 1'b0, 1'b0}},
      '{'{MODE_CREATE, 16'd0, 64'h0000_0000_ffff_ffff, 1'b1, 1'b1, 16'hffff}, 1'b1,
        '{ST_OK, 16'd257, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_READ, 16'd257, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_OK, 16'd0, 64'd1, 1'b0, 1'b0}},
      '{'{MODE_WRITE, 16'd257, '1, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_WOULDBLOCK, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_QUERY, 16'd257, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b0, NO_FIXED},
      '{'{MODE_CREATE, 16'd0, 64'd0, 1'b0, 1'b1, 16'd8}, 1'b1,
        '{ST_OK, 16'd258, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_READ, 16'd258, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_WOULDBLOCK, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_QUERY, 16'd255, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_BADHANDLE, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_QUERY, 16'd320, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b1,
        '{ST_BADHANDLE, 16'd0, 64'd0, 1'b0, 1'b0}},
      '{'{MODE_WRITE, 16'd258, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 16'd16}, 1'b0,
        NO_FIXED},
      '{'{MODE_READ, 16'd258, 64'd0, 1'b0, 1'b0, 16'd8}, 1'b0, NO_FIXED}
    };

    // Every block input is known from time zero, while reset is held low.
    rst_n                 <= 1'b0;
    in_bus.valid          <= 1'b0;
    in_bus.mode           <= MODE_CREATE;
    in_bus.handle         <= '0;
    in_bus.value          <= '0;
    in_bus.semaphore_mode <= 1'b0;
    in_bus.nonblocking    <= 1'b0;
    in_bus.request_bytes  <= '0;
    held_fixed            <= 1'b0;
    held_fixed_rs         <= NO_FIXED;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 25;
    stall_pct = 20;
    for (k = 0; k < NUM_DIRECTED; k++) begin
      put_request(directed_rows[k].rq, directed_rows[k].fixed, directed_rows[k].rs);
    end
    hold_for_drain();

    // Random part. Each chunk picks its own pressure so that calm stretches
    // alternate with heavy idling; the last two chunks run with none. Every
    // fourth chunk ends by waiting for the block to empty. Creates keep
    // coming after the bank is full, so the full case is hit many times.
    for (chunk = 0; chunk < NUM_CHUNKS; chunk++) begin
      if (chunk >= NUM_CHUNKS - 2) begin
        idle_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
      for (k = 0; k < CHUNK_ITEMS; k++) begin
        put_request(random_request(), 1'b0, NO_FIXED);
      end
      if (chunk % 4 == 3) hold_for_drain();
    end
    in_bus.valid <= 1'b0;

    // Wait for every owed result, then keep watching to catch strays.
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
